>>> hw/rtl/lsm_pkg.sv
// Shared types and constants for the lidar sector minimum block.
// No dependencies.
`default_nettype none
package lsm_pkg;

  localparam int ScanLengthDef = 1024;
  localparam int IdxW          = 10;
  localparam int DistW         = 16;
  localparam int ClassW        = 2;
  localparam int CfgIdxW       = 4;
  localparam int CfgDataW      = 16;

  localparam logic [ClassW-1:0] CLASS_VALID = 2'd0;
  localparam logic [ClassW-1:0] CLASS_NAN   = 2'd1;
  localparam logic [ClassW-1:0] CLASS_INF   = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_RIGHT_START  = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_END    = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_CENTER_START = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_CENTER_END   = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_LEFT_START   = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_LEFT_END     = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_NAN_SUB      = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_INF_SUB      = 4'd7;

  typedef struct packed {
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] stop;
  } win_bounds_t;

  typedef struct packed {
    win_bounds_t      right;
    win_bounds_t      center;
    win_bounds_t      left;
    logic [DistW-1:0] nan_sub;
    logic [DistW-1:0] inf_sub;
  } cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/lidar_sector_minimum_core.sv
// Lidar sector minimum: running minimum over three index windows of a scan.
// A last-sample beat passes the input register, then the output result registers.
// Throughput: one sample beat per cycle; the input register stalls only when
// a last sample meets a result that is still waiting at the output.
// Reset (rst_n low, synchronous) restores config defaults, clears index, windows and valids.
// Depends on lsm_pkg, lsm_cfg_regs, lsm_window.
`default_nettype none
module lidar_sector_minimum_core
  import lsm_pkg::*;
#(
  parameter int SCAN_LENGTH = ScanLengthDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [DistW-1:0]    in_range_mm,
  input  wire logic [ClassW-1:0]   in_sample_class,
  input  wire logic                in_last_sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [DistW-1:0]         out_min_left_mm,
  output logic [DistW-1:0]         out_min_center_mm,
  output logic [DistW-1:0]         out_min_right_mm,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  localparam int IdxLimitInt = (SCAN_LENGTH < (1 << IdxW)) ? SCAN_LENGTH : (1 << IdxW);
  localparam logic [IdxW:0] IdxLimit = IdxLimitInt[IdxW:0];

  cfg_t cfg;

  logic              stg_valid_r;
  logic [DistW-1:0]  stg_range_r;
  logic [ClassW-1:0] stg_class_r;
  logic              stg_last_r;
  logic              stg_adv;
  logic              in_fire;

  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic              ovf_r, ovf_nxt;
  logic [IdxW:0]     idx_inc;
  logic              win_step, win_clear;

  logic [DistW-1:0]  rep_left, rep_center, rep_right;
  logic              out_valid_r, out_valid_nxt;
  logic [DistW-1:0]  out_left_r, out_center_r, out_right_r;

  lsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign stg_adv   = stg_valid_r && (!stg_last_r || !out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || stg_adv;
  assign in_fire   = in_valid && in_ready;
  assign win_step  = stg_adv && !ovf_r;
  assign win_clear = stg_adv && stg_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_range_r <= in_range_mm;
      stg_class_r <= in_sample_class;
      stg_last_r  <= in_last_sample;
    end
  end

  always_comb begin
    idx_inc = {1'b0, idx_r} + {{IdxW{1'b0}}, 1'b1};
    idx_nxt = idx_r;
    ovf_nxt = ovf_r;
    if (stg_adv) begin
      if (stg_last_r) begin
        idx_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (!ovf_r) begin
        if (idx_inc >= IdxLimit) begin
          ovf_nxt = 1'b1;
        end else begin
          idx_nxt = idx_inc[IdxW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  lsm_window u_right (
    .clk (clk), .rst_n (rst_n), .step (win_step), .clear (win_clear),
    .idx (idx_r), .bounds (cfg.right), .range_mm (stg_range_r),
    .sample_class (stg_class_r), .nan_sub (cfg.nan_sub), .inf_sub (cfg.inf_sub),
    .report_mm (rep_right)
  );

  lsm_window u_center (
    .clk (clk), .rst_n (rst_n), .step (win_step), .clear (win_clear),
    .idx (idx_r), .bounds (cfg.center), .range_mm (stg_range_r),
    .sample_class (stg_class_r), .nan_sub (cfg.nan_sub), .inf_sub (cfg.inf_sub),
    .report_mm (rep_center)
  );

  lsm_window u_left (
    .clk (clk), .rst_n (rst_n), .step (win_step), .clear (win_clear),
    .idx (idx_r), .bounds (cfg.left), .range_mm (stg_range_r),
    .sample_class (stg_class_r), .nan_sub (cfg.nan_sub), .inf_sub (cfg.inf_sub),
    .report_mm (rep_left)
  );

  always_comb begin
    if (win_clear) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win_clear) begin
      out_left_r   <= rep_left;
      out_center_r <= rep_center;
      out_right_r  <= rep_right;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_min_left_mm   = out_left_r;
  assign out_min_center_mm = out_center_r;
  assign out_min_right_mm  = out_right_r;

endmodule
`default_nettype wire

>>> hw/rtl/lsm_cfg_regs.sv
// Configuration register file: window bounds and substitute distances.
// Depends on lsm_pkg.
`default_nettype none
module lsm_cfg_regs
  import lsm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_RIGHT_START:  cfg_nxt.right.first  = cfg_wdata[IdxW-1:0];
        REG_RIGHT_END:    cfg_nxt.right.stop   = cfg_wdata[IdxW-1:0];
        REG_CENTER_START: cfg_nxt.center.first = cfg_wdata[IdxW-1:0];
        REG_CENTER_END:   cfg_nxt.center.stop  = cfg_wdata[IdxW-1:0];
        REG_LEFT_START:   cfg_nxt.left.first   = cfg_wdata[IdxW-1:0];
        REG_LEFT_END:     cfg_nxt.left.stop    = cfg_wdata[IdxW-1:0];
        REG_NAN_SUB:      cfg_nxt.nan_sub      = cfg_wdata[DistW-1:0];
        REG_INF_SUB:      cfg_nxt.inf_sub      = cfg_wdata[DistW-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{right: '0, center: '0, left: '0, nan_sub: '0, inf_sub: '1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> hw/rtl/lsm_window.sv
// Running-minimum tracker for one sector window, with substitute reporting.
// Depends on lsm_pkg.
`default_nettype none
module lsm_window
  import lsm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              clear,
  input  wire logic [IdxW-1:0]   idx,
  input  wire win_bounds_t       bounds,
  input  wire logic [DistW-1:0]  range_mm,
  input  wire logic [ClassW-1:0] sample_class,
  input  wire logic [DistW-1:0]  nan_sub,
  input  wire logic [DistW-1:0]  inf_sub,
  output logic [DistW-1:0]       report_mm
);

  logic [DistW-1:0]  best_r, best_nxt, best_upd;
  logic [ClassW-1:0] cls_r, cls_nxt, cls_upd;
  logic              has_r, has_nxt, has_upd;
  logic              hit;
  logic              take;

  always_comb begin
    if (bounds.first >= bounds.stop) begin
      hit = (idx == bounds.stop);
    end else begin
      hit = (idx >= bounds.first) && (idx < bounds.stop);
    end
    take = step && hit &&
           (!has_r || ((sample_class == CLASS_VALID) &&
                       ((cls_r != CLASS_VALID) || (range_mm < best_r))));
    best_upd = take ? range_mm : best_r;
    cls_upd  = take ? sample_class : cls_r;
    has_upd  = has_r || (step && hit);

    if (cls_upd == CLASS_VALID) begin
      report_mm = best_upd;
    end else if (cls_upd == CLASS_NAN) begin
      report_mm = nan_sub;
    end else begin
      report_mm = inf_sub;
    end

    if (clear) begin
      best_nxt = '0;
      cls_nxt  = CLASS_VALID;
      has_nxt  = 1'b0;
    end else begin
      best_nxt = best_upd;
      cls_nxt  = cls_upd;
      has_nxt  = has_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
      cls_r  <= CLASS_VALID;
      has_r  <= 1'b0;
    end else begin
      best_r <= best_nxt;
      cls_r  <= cls_nxt;
      has_r  <= has_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lsm_checker.sv
// Port-level checks for lidar_sector_minimum_core, attached by bind.
// Depends on lsm_pkg and lidar_sector_minimum_core.
`default_nettype none
module lsm_checker
  import lsm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DistW-1:0]  out_min_left_mm,
  input wire logic [DistW-1:0]  out_min_center_mm,
  input wire logic [DistW-1:0]  out_min_right_mm
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_left_mm) &&
      $stable(out_min_center_mm) && $stable(out_min_right_mm))
    else $error("stalled result beat changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result beat");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat dropped before accept");

endmodule

bind lidar_sector_minimum_core lsm_checker u_lsm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_min_left_mm   (out_min_left_mm),
  .out_min_center_mm (out_min_center_mm),
  .out_min_right_mm  (out_min_right_mm)
);
`default_nettype wire
